FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. They compile away in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The condition must never hold at a clock edge.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: condition must never hold");

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_NEVER(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/chs_pkg.sv
package chs_pkg;

   // Default geometry of the table.
   localparam int NUM_BUCKETS_DEF = 32;
   localparam int POOL_SIZE_DEF   = 64;
   localparam int KEY_BITS_DEF    = 16;

   // Fixed widths of the port fields.
   localparam int KEY_PORT_W    = 16;
   localparam int BUCKET_PORT_W = 5;
   localparam int STATUS_W      = 2;
   localparam int SLOT_PORT_W   = 6;

   // Key bits folded into the bucket remainder per clock.
   localparam int HASH_BITS_PER_CYCLE = 4;

   // Words held between the hash front end and the chain walker.
   localparam int QUEUE_DEPTH = 2;

   // Result codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_FOUND     = 2'd0,
      ST_INSERTED  = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

endpackage

FILE: rtl/chs_front.sv
module chs_front import chs_pkg::*; #(
   parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
   parameter int KEY_BITS    = KEY_BITS_DEF,
   localparam int BKT_W      = $clog2(NUM_BUCKETS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clearing,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_opcode,
   input  logic [KEY_PORT_W-1:0] req_key,
   output logic                  push_valid,
   input  logic                  push_ready,
   output logic                  push_opcode,
   output logic [KEY_BITS-1:0]   push_key,
   output logic [BKT_W-1:0]      push_bucket
);

   localparam int HBPC     = HASH_BITS_PER_CYCLE;
   localparam int PAD_BITS = ((KEY_BITS + HBPC - 1) / HBPC) * HBPC;
   localparam int STEPS    = PAD_BITS / HBPC;
   localparam int STEP_W   = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam logic [BKT_W:0]    NB_EXT    = (BKT_W + 1)'(NUM_BUCKETS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_CALC = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type       state_ff, state_in;
   logic [STEP_W-1:0]     cnt_ff, cnt_in;
   logic                  op_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [PAD_BITS-1:0]   sh_ff;
   logic [BKT_W-1:0]      rem_ff;
   logic [BKT_W-1:0]      rem_nx;
   logic                  accept;

   // One restoring remainder step: shift in a key bit, subtract once if needed.
   function automatic logic [BKT_W-1:0] rem_step(input logic [BKT_W-1:0] r, input logic b);
      logic [BKT_W:0] t;
      t = {r, b};
      if (t >= NB_EXT) begin
         t = t - NB_EXT;
      end
      return t[BKT_W-1:0];
   endfunction

   assign req_ready = (state_ff == F_IDLE) && !clearing;
   assign accept    = req_valid && req_ready;

   // Fold the next group of key bits, most significant first.
   always_comb begin
      rem_nx = rem_ff;
      for (int i = 0; i < HBPC; i++) begin
         rem_nx = rem_step(rem_nx, sh_ff[PAD_BITS-1-i]);
      end
   end

   // Sequencer for accept, remainder iterations and hand-off.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         F_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               state_in = F_CALC;
            end
         end
         F_CALC: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Word payload and the running remainder.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_opcode;
         key_ff <= KEY_BITS'(req_key);
         sh_ff  <= PAD_BITS'(KEY_BITS'(req_key));
         rem_ff <= '0;
      end else if (state_ff == F_CALC) begin
         sh_ff  <= sh_ff << HBPC;
         rem_ff <= rem_nx;
      end
   end

   assign push_valid  = (state_ff == F_PUSH);
   assign push_opcode = op_ff;
   assign push_key    = key_ff;
   assign push_bucket = rem_ff;

endmodule

FILE: rtl/chs_queue.sv
`include "assert_macros.svh"

module chs_queue import chs_pkg::*; #(
   parameter int WIDTH = 1,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             push, pop;

   assign wr_ready = (cnt_ff != CNT_FULL);
   assign rd_valid = (cnt_ff != '0);
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;
   assign rd_data  = slot_ff[rd_ptr_ff];

   // Pointers wrap at the depth; the count tracks occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `ASSERT_NEVER(a_queue_count_bound, clock, reset, cnt_ff > CNT_FULL)
   `ASSERT_NEXT(a_queue_push_grows, clock, reset, push && !pop, cnt_ff != '0)
   `ASSERT_IMPLY(a_queue_ptr_agree, clock, reset, cnt_ff == '0, wr_ptr_ff == rd_ptr_ff)

endmodule

FILE: rtl/chs_back.sv
`include "assert_macros.svh"

module chs_back import chs_pkg::*; #(
   parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
   parameter int POOL_SIZE   = POOL_SIZE_DEF,
   parameter int KEY_BITS    = KEY_BITS_DEF,
   localparam int BKT_W      = $clog2(NUM_BUCKETS)
) (
   input  logic                     clock,
   input  logic                     reset,
   output logic                     clearing,
   input  logic                     q_valid,
   output logic                     q_pop,
   input  logic                     q_opcode,
   input  logic [KEY_BITS-1:0]      q_key,
   input  logic [BKT_W-1:0]         q_bucket,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [BUCKET_PORT_W-1:0] rsp_bucket,
   output status_type               rsp_status,
   output logic [SLOT_PORT_W-1:0]   rsp_entry_slot
);

   localparam int SLOT_W = $clog2(POOL_SIZE);
   localparam int UCNT_W = $clog2(POOL_SIZE + 1);
   localparam logic [UCNT_W-1:0] USED_MAX = UCNT_W'(POOL_SIZE);
   localparam logic [UCNT_W-1:0] USED_ONE = UCNT_W'(1);
   localparam logic [BKT_W-1:0]  BKT_LAST = BKT_W'(NUM_BUCKETS - 1);

   typedef enum logic [4:0] {
      B_CLEAR  = 5'b00001,
      B_IDLE   = 5'b00010,
      B_HEAD   = 5'b00100,
      B_WALK   = 5'b01000,
      B_DECIDE = 5'b10000
   } back_state_type;

   // Bucket heads and chain links hold a valid bit above the slot number.
   logic [SLOT_W:0]    head_mem [NUM_BUCKETS];
   logic [KEY_BITS-1:0] key_mem [POOL_SIZE];
   logic [SLOT_W:0]    link_mem [POOL_SIZE];

   back_state_type      state_ff, state_in;
   logic [BKT_W-1:0]    clr_ff;
   logic [UCNT_W-1:0]   used_ff;
   logic                op_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [BKT_W-1:0]    bkt_ff;
   logic [SLOT_W-1:0]   cur_ff, cur_in;
   logic [SLOT_W:0]     head_rd_ff;
   logic [KEY_BITS-1:0] key_rd_ff;
   logic [SLOT_W:0]     link_rd_ff;

   logic                rsp_valid_ff;
   logic [BUCKET_PORT_W-1:0] rsp_bucket_ff;
   status_type          rsp_status_ff;
   logic [SLOT_PORT_W-1:0] rsp_slot_ff;

   logic                out_free;
   logic                load;
   status_type          status_res;
   logic [SLOT_W-1:0]   slot_res;
   logic                ins_we;
   logic [SLOT_W-1:0]   new_slot;
   logic                head_re;
   logic                ent_re;
   logic [SLOT_W-1:0]   ent_addr;
   logic                head_we;
   logic [BKT_W-1:0]    head_waddr;
   logic [SLOT_W:0]     head_wdata;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign new_slot = used_ff[SLOT_W-1:0];
   assign clearing = (state_ff == B_CLEAR);

   // Chain walk sequencer.
   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      q_pop      = 1'b0;
      head_re    = 1'b0;
      ent_re     = 1'b0;
      ent_addr   = cur_ff;
      load       = 1'b0;
      ins_we     = 1'b0;
      status_res = ST_NOT_FOUND;
      slot_res   = '0;
      unique case (state_ff)
         B_CLEAR: begin
            if (clr_ff == BKT_LAST) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               head_re  = 1'b1;
               state_in = B_HEAD;
            end
         end
         B_HEAD: begin
            if (head_rd_ff[SLOT_W]) begin
               ent_re   = 1'b1;
               ent_addr = head_rd_ff[SLOT_W-1:0];
               cur_in   = head_rd_ff[SLOT_W-1:0];
               state_in = B_WALK;
            end else begin
               state_in = B_DECIDE;
            end
         end
         B_WALK: begin
            if (key_rd_ff == key_ff) begin
               if (out_free) begin
                  load       = 1'b1;
                  status_res = ST_FOUND;
                  slot_res   = cur_ff;
                  state_in   = B_IDLE;
               end
            end else if (link_rd_ff[SLOT_W]) begin
               ent_re   = 1'b1;
               ent_addr = link_rd_ff[SLOT_W-1:0];
               cur_in   = link_rd_ff[SLOT_W-1:0];
            end else begin
               state_in = B_DECIDE;
            end
         end
         B_DECIDE: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = B_IDLE;
               priority if (!op_ff) begin
                  status_res = ST_NOT_FOUND;
               end else if (used_ff >= USED_MAX) begin
                  status_res = ST_FULL;
               end else begin
                  ins_we     = 1'b1;
                  status_res = ST_INSERTED;
                  slot_res   = new_slot;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // Head table write port: clearing sweep or new chain head.
   always_comb begin
      head_we    = clearing || ins_we;
      head_waddr = clearing ? clr_ff : bkt_ff;
      head_wdata = clearing ? '0 : {1'b1, new_slot};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= load || (rsp_valid_ff && !rsp_ready);
         if (clearing) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (ins_we) begin
            used_ff <= used_ff + USED_ONE;
         end
      end
   end

   // Item payload, walk position and response registers.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         op_ff  <= q_opcode;
         key_ff <= q_key;
         bkt_ff <= q_bucket;
      end
      cur_ff <= cur_in;
      if (load) begin
         rsp_bucket_ff <= BUCKET_PORT_W'(bkt_ff);
         rsp_status_ff <= status_res;
         rsp_slot_ff   <= SLOT_PORT_W'(slot_res);
      end
   end

   // Head table.
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
      if (head_re) begin
         head_rd_ff <= head_mem[q_bucket];
      end
   end

   // Entry pool: key and link, written together on insert.
   always_ff @(posedge clock) begin
      if (ins_we) begin
         key_mem[new_slot]  <= key_ff;
         link_mem[new_slot] <= head_rd_ff;
      end
      if (ent_re) begin
         key_rd_ff  <= key_mem[ent_addr];
         link_rd_ff <= link_mem[ent_addr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bucket     = rsp_bucket_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_entry_slot = rsp_slot_ff;

   `ASSERT_NEVER(a_used_bound, clock, reset, used_ff > USED_MAX)
   `ASSERT_IMPLY(a_no_pop_clear, clock, reset, clearing, !q_pop && !ins_we)
   `ASSERT_NEXT(a_insert_count, clock, reset, ins_we, used_ff == $past(used_ff) + USED_ONE)
   `ASSERT_IMPLY(a_load_free, clock, reset, load, out_free)

endmodule

FILE: rtl/chained_hash_set_insert_core.sv
// Chained hash set with lookup and insert-if-absent over a fixed entry pool.
// Each request word carries an opcode and a key; each returns exactly one
// response word with the bucket (key modulo NUM_BUCKETS), a status (found,
// inserted, not found, pool full) and the entry slot, in request order.
// A front end computes the bucket remainder HASH_BITS_PER_CYCLE key bits per
// clock, then hands the word off. A two-word queue feeds the chain walker,
// which makes one pool read per chain entry compared. The front end and the
// walker each take a new word only after finishing the last one; the queue
// lets them work on different words at once. After reset the walker sweeps
// the bucket head table, one bucket per cycle; req_ready stays low during
// that sweep.
module chained_hash_set_insert_core import chs_pkg::*; #(
   parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
   parameter int POOL_SIZE   = POOL_SIZE_DEF,
   parameter int KEY_BITS    = KEY_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_opcode,
   input  logic [KEY_PORT_W-1:0]    req_key,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [BUCKET_PORT_W-1:0] rsp_bucket,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [SLOT_PORT_W-1:0]   rsp_entry_slot
);

   localparam int BKT_W = $clog2(NUM_BUCKETS);
   localparam int QW    = 1 + KEY_BITS + BKT_W;

   logic                clearing;
   logic                f_valid, f_ready;
   logic                f_opcode;
   logic [KEY_BITS-1:0] f_key;
   logic [BKT_W-1:0]    f_bucket;
   logic                q_valid, q_pop;
   logic [QW-1:0]       q_data;
   status_type          status;

   chs_front #(
      .NUM_BUCKETS (NUM_BUCKETS),
      .KEY_BITS    (KEY_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .clearing    (clearing),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .req_key     (req_key),
      .push_valid  (f_valid),
      .push_ready  (f_ready),
      .push_opcode (f_opcode),
      .push_key    (f_key),
      .push_bucket (f_bucket)
   );

   chs_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (f_valid),
      .wr_ready (f_ready),
      .wr_data  ({f_opcode, f_key, f_bucket}),
      .rd_valid (q_valid),
      .rd_ready (q_pop),
      .rd_data  (q_data)
   );

   chs_back #(
      .NUM_BUCKETS (NUM_BUCKETS),
      .POOL_SIZE   (POOL_SIZE),
      .KEY_BITS    (KEY_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .clearing       (clearing),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_opcode       (q_data[QW-1]),
      .q_key          (q_data[QW-2:BKT_W]),
      .q_bucket       (q_data[BKT_W-1:0]),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_bucket     (rsp_bucket),
      .rsp_status     (status),
      .rsp_entry_slot (rsp_entry_slot)
   );

   assign rsp_status = status;

endmodule
